/* hw/rtl/tone_queue_pwm_sequencer_unit_defines.svh */
// Assertion macros for the tone queue sequencer
`ifndef TONE_QUEUE_PWM_SEQUENCER_UNIT_DEFINES_SVH
`define TONE_QUEUE_PWM_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TQPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TQPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tqps_pkg.sv */
// Package: widths, codes, types and constants of the tone queue sequencer
`timescale 1ns / 1ps
`default_nettype none
package tqps_pkg;

  localparam int FREQ_W      = 20;
  localparam int MS_W        = 16;
  localparam int CLK_W       = 24;
  localparam int CMP_W       = 23;
  localparam int QCNT_W      = 8;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int DIV_STEPS   = CLK_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CLK_W-1:0] CLOCK_RESET = 24'd1000000;

  // register index taken from paddr[2]
  localparam logic REG_TIMER_CLOCK = 1'b0;

  typedef enum logic {
    REQ_PLAY = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_ACCEPTED = 2'd0,
    STAT_IGNORED  = 2'd1,
    STAT_DROPPED  = 2'd2,
    STAT_TICK     = 2'd3
  } req_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_START,
    ST_DIV,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } tone_t;

  typedef struct packed {
    logic              start;
    logic [CLK_W-1:0]  dividend;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* hw/rtl/tqps_stream_if.sv */
// Stream interfaces for request items and result items
`timescale 1ns / 1ps
`default_nettype none
interface tqps_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [tqps_pkg::FREQ_W-1:0]   tone_freq;
  logic [tqps_pkg::MS_W-1:0]     tone_ms;

  modport source (output valid, output req_type, output tone_freq, output tone_ms,
                  input ready);
  modport sink   (input valid, input req_type, input tone_freq, input tone_ms,
                  output ready);
endinterface

interface tqps_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_status;
  logic                          pwm_on;
  logic [tqps_pkg::CLK_W-1:0]    pwm_period;
  logic [tqps_pkg::CMP_W-1:0]    pwm_compare;
  logic [tqps_pkg::MS_W-1:0]     ms_left;
  logic [tqps_pkg::QCNT_W-1:0]   queued_count;

  modport source (output valid, output req_status, output pwm_on, output pwm_period,
                  output pwm_compare, output ms_left, output queued_count,
                  input ready);
  modport sink   (input valid, input req_status, input pwm_on, input pwm_period,
                  input pwm_compare, input ms_left, input queued_count,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/tone_queue_pwm_sequencer_unit.sv */
// Top level: tone queue sequencer with ring memory, period divider and result register
//
// Usage:
//   in_ch carries items: a play request (req_type 0, tone_freq, tone_ms) or a
//   one millisecond tick (req_type 1). Every item gives exactly one result on
//   out_ch: the status and the PWM state after the item (pwm_on, pwm_period,
//   pwm_compare, ms_left, queued_count).
//   The APB port holds timer_clock_hz at address 0; write it only while idle.
//   Path from acceptance to out_ch.valid: EXEC and FINISH for items that start no
//   tone, EXEC, START and FINISH for a silent tone, EXEC, START, DIV and FINISH for
//   a tone that needs a period. The restoring divider in DIV sets the worst case;
//   one item is in work at a time, so a new item is taken only after FINISH.
//   A queued tone read from the ring passes through ST_READ before START.
//   The result register decouples the sides: the next item is taken while a
//   result still waits; if out_ch stalls, the following result holds inside
//   and in_ch.ready stays low until the register drains.
//   Reset: ring empty, no tone playing, period and compare 0, timer clock
//   1000000. The ring contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "tone_queue_pwm_sequencer_unit_defines.svh"
module tone_queue_pwm_sequencer_unit #(
  parameter int QUEUE_DEPTH = tqps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  tqps_req_if.sink                                in_ch,
  tqps_rsp_if.source                              out_ch,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tqps_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [tqps_pkg::DATA_W-1:0]        pwdata,
  output logic [tqps_pkg::DATA_W-1:0]             prdata,
  output logic                                    pready
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = PTR_W + 1;
  localparam int FREQ_W = tqps_pkg::FREQ_W;
  localparam int MS_W   = tqps_pkg::MS_W;
  localparam int CLK_W  = tqps_pkg::CLK_W;
  localparam int CMP_W  = tqps_pkg::CMP_W;
  localparam int QCNT_W = tqps_pkg::QCNT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  // ---------------- configuration ----------------
  logic [CLK_W-1:0] clk_hz_r;
  logic             reg_hit;

  assign reg_hit = (paddr[2] == tqps_pkg::REG_TIMER_CLOCK);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(tqps_pkg::DATA_W - CLK_W){1'b0}}, clk_hz_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= tqps_pkg::CLOCK_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      clk_hz_r <= pwdata[CLK_W-1:0];
    end
  end

  // ---------------- state ----------------
  tqps_pkg::seq_state_t state_r, state_nxt;

  logic              item_tick_r, item_tick_nxt;
  logic [FREQ_W-1:0] item_freq_r, item_freq_nxt;
  logic [MS_W-1:0]   item_ms_r, item_ms_nxt;

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic              playing_r, playing_nxt;
  logic [MS_W-1:0]   rem_ms_r, rem_ms_nxt;
  logic [CLK_W-1:0]  period_r, period_nxt;
  logic [CMP_W-1:0]  compare_r, compare_nxt;
  logic [FREQ_W-1:0] tone_freq_r, tone_freq_nxt;

  tqps_pkg::req_status_t status_r, status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_on_r, out_on_nxt;
  logic [CLK_W-1:0]  out_period_r, out_period_nxt;
  logic [CMP_W-1:0]  out_compare_r, out_compare_nxt;
  logic [MS_W-1:0]   out_ms_r, out_ms_nxt;
  logic [QCNT_W-1:0] out_qcnt_r, out_qcnt_nxt;

  // ---------------- ring and divider ----------------
  logic              ring_wr_en;
  tqps_pkg::tone_t   ring_wr_data;
  logic              ring_rd_en;
  tqps_pkg::tone_t   ring_rd_data;
  tqps_pkg::div_req_t div_req;
  tqps_pkg::div_rsp_t div_rsp;

  tqps_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (ring_wr_data),
    .rd_en   (ring_rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (ring_rd_data)
  );

  tqps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------- decisions ----------------
  logic             in_fire;
  logic             out_free;
  logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
  logic             ring_empty, ring_full;
  logic             tick_dec, tick_end;
  logic             play_zero, play_ok;
  logic [CNT_W-1:0] ring_cnt;

  assign in_ch.ready = (state_r == tqps_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign ring_empty = (rd_ptr_r == wr_ptr_r);
  assign ring_full  = (wr_ptr_inc == rd_ptr_r);
  assign ring_cnt   = {1'b0, wr_ptr_r} - {1'b0, rd_ptr_r}
                    + ((wr_ptr_r < rd_ptr_r) ? CNT_W'(QUEUE_DEPTH) : '0);

  assign tick_dec  = item_tick_r && playing_r && (rem_ms_r != '0);
  assign tick_end  = tick_dec && (rem_ms_r == MS_W'(1));
  assign play_zero = !item_tick_r && (item_ms_r == '0);
  assign play_ok   = !item_tick_r && !play_zero && !ring_full;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tqps_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = tqps_pkg::ST_EXEC;
      end
      tqps_pkg::ST_EXEC: begin
        priority if (tick_end && !ring_empty) state_nxt = tqps_pkg::ST_READ;
        else if (play_ok && !playing_r)       state_nxt = tqps_pkg::ST_START;
        else                                  state_nxt = tqps_pkg::ST_FINISH;
      end
      tqps_pkg::ST_READ: begin
        state_nxt = tqps_pkg::ST_START;
      end
      tqps_pkg::ST_START: begin
        state_nxt = (tone_freq_r == '0) ? tqps_pkg::ST_FINISH : tqps_pkg::ST_DIV;
      end
      tqps_pkg::ST_DIV: begin
        if (div_rsp.done) state_nxt = tqps_pkg::ST_FINISH;
      end
      tqps_pkg::ST_FINISH: begin
        if (out_free) state_nxt = tqps_pkg::ST_IDLE;
      end
      default: state_nxt = tqps_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath control ----------------
  always_comb begin
    item_tick_nxt   = item_tick_r;
    item_freq_nxt   = item_freq_r;
    item_ms_nxt     = item_ms_r;
    rd_ptr_nxt      = rd_ptr_r;
    wr_ptr_nxt      = wr_ptr_r;
    playing_nxt     = playing_r;
    rem_ms_nxt      = rem_ms_r;
    period_nxt      = period_r;
    compare_nxt     = compare_r;
    tone_freq_nxt   = tone_freq_r;
    status_nxt      = status_r;
    ring_wr_en      = 1'b0;
    ring_wr_data    = '{freq: item_freq_r, ms: item_ms_r};
    ring_rd_en      = 1'b0;
    div_req         = '{start: 1'b0, dividend: clk_hz_r, divisor: tone_freq_r};
    out_status_nxt  = out_status_r;
    out_on_nxt      = out_on_r;
    out_period_nxt  = out_period_r;
    out_compare_nxt = out_compare_r;
    out_ms_nxt      = out_ms_r;
    out_qcnt_nxt    = out_qcnt_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;

    unique case (state_r)
      tqps_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_tick_nxt = in_ch.req_type;
          item_freq_nxt = in_ch.tone_freq;
          item_ms_nxt   = in_ch.tone_ms;
        end
      end
      tqps_pkg::ST_EXEC: begin
        priority if (item_tick_r) begin
          status_nxt = tqps_pkg::STAT_TICK;
          if (tick_dec) rem_ms_nxt = rem_ms_r - 1'b1;
          if (tick_end) begin
            if (ring_empty) begin
              playing_nxt = 1'b0;
            end else begin
              // fetch the head; data arrives next cycle
              ring_rd_en = 1'b1;
              rd_ptr_nxt = rd_ptr_inc;
            end
          end
        end else if (play_zero) begin
          status_nxt = tqps_pkg::STAT_IGNORED;
        end else if (ring_full) begin
          status_nxt = tqps_pkg::STAT_DROPPED;
        end else begin
          status_nxt = tqps_pkg::STAT_ACCEPTED;
          ring_wr_en = 1'b1;
          wr_ptr_nxt = wr_ptr_inc;
          if (!playing_r) begin
            // ring was empty: the new entry is the head, forward it
            rd_ptr_nxt    = rd_ptr_inc;
            rem_ms_nxt    = item_ms_r;
            tone_freq_nxt = item_freq_r;
          end
        end
      end
      tqps_pkg::ST_READ: begin
        rem_ms_nxt    = ring_rd_data.ms;
        tone_freq_nxt = ring_rd_data.freq;
      end
      tqps_pkg::ST_START: begin
        if (tone_freq_r == '0) begin
          period_nxt  = CLK_W'(1);
          playing_nxt = 1'b1;
        end else begin
          div_req.start = 1'b1;
        end
      end
      tqps_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          period_nxt  = div_rsp.quotient;
          compare_nxt = div_rsp.quotient[CLK_W-1:1];
          playing_nxt = 1'b1;
        end
      end
      tqps_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_on_nxt      = playing_r;
          out_period_nxt  = period_r;
          out_compare_nxt = compare_r;
          out_ms_nxt      = rem_ms_r;
          out_qcnt_nxt    = QCNT_W'(ring_cnt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tqps_pkg::ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      playing_r   <= 1'b0;
      rem_ms_r    <= '0;
      period_r    <= '0;
      compare_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      playing_r   <= playing_nxt;
      rem_ms_r    <= rem_ms_nxt;
      period_r    <= period_nxt;
      compare_r   <= compare_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_tick_r   <= item_tick_nxt;
    item_freq_r   <= item_freq_nxt;
    item_ms_r     <= item_ms_nxt;
    tone_freq_r   <= tone_freq_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_on_r      <= out_on_nxt;
    out_period_r  <= out_period_nxt;
    out_compare_r <= out_compare_nxt;
    out_ms_r      <= out_ms_nxt;
    out_qcnt_r    <= out_qcnt_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.req_status   = out_status_r;
  assign out_ch.pwm_on       = out_on_r;
  assign out_ch.pwm_period   = out_period_r;
  assign out_ch.pwm_compare  = out_compare_r;
  assign out_ch.ms_left      = out_ms_r;
  assign out_ch.queued_count = out_qcnt_r;

  // ---------------- assertions ----------------
  `TQPS_ASSERT_NOW(a_idle_ring_empty, !playing_r, rd_ptr_r == wr_ptr_r, "ring not empty while idle")
  `TQPS_ASSERT_NOW(a_playing_has_ms, (state_r == tqps_pkg::ST_IDLE) && playing_r, rem_ms_r != '0, "tone playing with no ms left")
  `TQPS_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_r == tqps_pkg::ST_DIV, "divider result outside divide state")
  `TQPS_ASSERT_NEXT(a_finish_holds, (state_r == tqps_pkg::ST_FINISH) && out_ch.valid && !out_ch.ready, state_r == tqps_pkg::ST_FINISH, "result left while output register full")

endmodule
`default_nettype wire

/* hw/rtl/tqps_ring.sv */
// Tone ring memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module tqps_ring #(
  parameter int QUEUE_DEPTH = tqps_pkg::QUEUE_DEPTH_DEF,
  localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [PTR_W-1:0] wr_addr,
  input  wire tqps_pkg::tone_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [PTR_W-1:0] rd_addr,
  output tqps_pkg::tone_t      rd_data
);

  tqps_pkg::tone_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tqps_div.sv */
// Restoring divider: 24-bit dividend by 20-bit divisor, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module tqps_div (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire tqps_pkg::div_req_t req,
  output tqps_pkg::div_rsp_t rsp
);

  localparam int CLK_W  = tqps_pkg::CLK_W;
  localparam int FREQ_W = tqps_pkg::FREQ_W;
  localparam int CNT_W  = tqps_pkg::DIV_CNT_W;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tqps_pkg::DIV_STEPS - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CLK_W-1:0]  num_r, num_nxt;
  logic [FREQ_W-1:0] den_r, den_nxt;
  logic [FREQ_W-1:0] rem_r, rem_nxt;
  logic [FREQ_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, num_r[CLK_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift the quotient bit in where the dividend bit leaves
      rem_nxt = fits ? FREQ_W'(trial - {1'b0, den_r}) : trial[FREQ_W-1:0];
      num_nxt = {num_r[CLK_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = num_r;

endmodule
`default_nettype wire

/* tb/sv/tone_queue_pwm_sequencer_unit_test.sv */
// Testbench for the tone queue sequencer: directed and random transactions checked by a predictor
`timescale 1ns / 1ps
module tone_queue_pwm_sequencer_unit_test;
  import tqps_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [ADDR_W-1:0] TIMER_CLOCK_ADDR = {REG_TIMER_CLOCK, 2'b00};
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
  localparam logic [MS_W-1:0] MS_MAX = '1;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    req_type_t         kind;
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } tone_item_t;

  typedef struct {
    req_status_t       status;
    logic              pwm_on;
    logic [CLK_W-1:0]  period;
    logic [CMP_W-1:0]  compare;
    logic [MS_W-1:0]   ms_left;
    logic [QCNT_W-1:0] queued;
  } pwm_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tqps_req_if in_ch();
  tqps_rsp_if out_ch();

  logic send_valid = 1'b0;
  tone_item_t send_item = '{REQ_PLAY, '0, '0};
  logic take_ready = 1'b0;

  assign in_ch.valid     = send_valid;
  assign in_ch.req_type  = send_item.kind;
  assign in_ch.tone_freq = send_item.freq;
  assign in_ch.tone_ms   = send_item.ms;
  assign out_ch.ready    = take_ready;

  tone_queue_pwm_sequencer_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tone_item_t tone_items_to_send[$];
  pwm_state_t expected_states[$];
  int error_count = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 73;
  logic hold_trigger = 1'b0;
  int stall_left = 0;

  // predictor state
  logic [FREQ_W-1:0] ring_tone_freq [DEPTH];
  logic [MS_W-1:0]   ring_tone_ms [DEPTH];
  int unsigned       head_idx;
  int unsigned       tail_idx;
  logic              tone_playing;
  logic [MS_W-1:0]   ms_remaining;
  logic [CLK_W-1:0]  period_now;
  logic [CMP_W-1:0]  compare_now;
  logic [CLK_W-1:0]  timer_clock_hz;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1) % DEPTH;
  endfunction

  task automatic start_queued_tone();
    logic [FREQ_W-1:0] f;
    if (head_idx == tail_idx) begin
      tone_playing = 1'b0;
      return;
    end
    f = ring_tone_freq[head_idx];
    ms_remaining = ring_tone_ms[head_idx];
    head_idx = next_slot(head_idx);
    // silent tone: period 1, compare holds its old value
    if (f == '0) begin
      period_now = CLK_W'(1);
    end else begin
      period_now = timer_clock_hz / f;
      compare_now = CMP_W'(period_now >> 1);
    end
    tone_playing = 1'b1;
  endtask

  task automatic predict_tone_item(input tone_item_t it);
    pwm_state_t want;
    if (it.kind == REQ_TICK) begin
      want.status = STAT_TICK;
      if (tone_playing && ms_remaining != '0) begin
        ms_remaining = ms_remaining - 1'b1;
        if (ms_remaining == '0) start_queued_tone();
      end
    end else if (it.ms == '0) begin
      want.status = STAT_IGNORED;
    end else if (next_slot(tail_idx) == head_idx) begin
      want.status = STAT_DROPPED;
    end else begin
      want.status = STAT_ACCEPTED;
      ring_tone_freq[tail_idx] = it.freq;
      ring_tone_ms[tail_idx] = it.ms;
      tail_idx = next_slot(tail_idx);
      if (!tone_playing) start_queued_tone();
    end
    want.pwm_on  = tone_playing;
    want.period  = period_now;
    want.compare = compare_now;
    want.ms_left = ms_remaining;
    want.queued  = QCNT_W'((tail_idx + DEPTH - head_idx) % DEPTH);
    expected_states.push_back(want);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 100)
      $display("%0t: %s got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_result();
    pwm_state_t want;
    if (expected_states.size() == 0) begin
      report_mismatch("unexpected transaction, req_status", out_ch.req_status, '0);
      return;
    end
    want = expected_states.pop_front();
    if (out_ch.req_status !== want.status)
      report_mismatch("req_status", out_ch.req_status, want.status);
    if (out_ch.pwm_on !== want.pwm_on)
      report_mismatch("pwm_on", out_ch.pwm_on, want.pwm_on);
    if (out_ch.pwm_period !== want.period)
      report_mismatch("pwm_period", out_ch.pwm_period, want.period);
    if (out_ch.pwm_compare !== want.compare)
      report_mismatch("pwm_compare", out_ch.pwm_compare, want.compare);
    if (out_ch.ms_left !== want.ms_left)
      report_mismatch("ms_left", out_ch.ms_left, want.ms_left);
    if (out_ch.queued_count !== want.queued)
      report_mismatch("queued_count", out_ch.queued_count, want.queued);
  endtask

  // driver: offer queued items, predict each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      send_valid <= 1'b0;
      head_idx = 0;
      tail_idx = 0;
      tone_playing = 1'b0;
      ms_remaining = '0;
      period_now = '0;
      compare_now = '0;
      timer_clock_hz = CLOCK_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == TIMER_CLOCK_ADDR)
        timer_clock_hz = pwdata[CLK_W-1:0];
      if (send_valid && in_ch.ready) predict_tone_item(send_item);
      if (!send_valid || in_ch.ready) begin
        if (tone_items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          send_item <= tone_items_to_send.pop_front();
          send_valid <= 1'b1;
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, check each transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      take_ready <= 1'b0;
    end else begin
      if (out_ch.valid && take_ready) check_result();
      take_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_trigger) begin
      stall_left <= HOLD_CYCLES;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  function automatic tone_item_t play_item(input logic [FREQ_W-1:0] freq,
                                           input logic [MS_W-1:0] ms);
    tone_item_t it;
    it.kind = REQ_PLAY;
    it.freq = freq;
    it.ms = ms;
    return it;
  endfunction

  // tick fields carry noise, the block must ignore them
  function automatic tone_item_t tick_item();
    tone_item_t it;
    it.kind = REQ_TICK;
    it.freq = FREQ_W'($urandom());
    it.ms = MS_W'($urandom());
    return it;
  endfunction

  function automatic logic [FREQ_W-1:0] random_freq();
    case ($urandom_range(3))
      0: return '0;
      1: return FREQ_W'($urandom_range(1, 20));
      2: return FREQ_W'($urandom_range(1, 2000));
      default: return FREQ_W'($urandom());
    endcase
  endfunction

  task automatic queue_random_traffic(input int n);
    int done;
    int pick;
    int burst;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        // burst of requests to fill the ring and force drops
        burst = $urandom_range(6, 10);
        repeat (burst)
          tone_items_to_send.push_back(play_item(random_freq(), MS_W'($urandom_range(1, 3))));
        done += burst;
      end else if (pick < 62) begin
        tone_items_to_send.push_back(tick_item());
        done++;
      end else if (pick < 66) begin
        tone_items_to_send.push_back(play_item(FREQ_W'($urandom()), '0));
      end else if ($urandom_range(99) < 85) begin
        tone_items_to_send.push_back(play_item(random_freq(), MS_W'($urandom_range(1, 3))));
        done++;
      end else begin
        tone_items_to_send.push_back(play_item(random_freq(), MS_W'($urandom_range(4, 60))));
        done++;
      end
    end
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (tone_items_to_send.size() != 0 || send_valid || expected_states.size() != 0);
  endtask

  task automatic write_timer_clock(input logic [CLK_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= TIMER_CLOCK_ADDR;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [CLK_W-1:0] clock_setting;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle tick, zero duration, special periods, stop, full ring
    tone_items_to_send.push_back('{REQ_TICK, FREQ_MAX, MS_MAX});
    tone_items_to_send.push_back(play_item(FREQ_W'(1234), '0));
    tone_items_to_send.push_back(play_item(FREQ_W'(1000), MS_W'(2)));
    tone_items_to_send.push_back(play_item('0, MS_W'(1)));
    tone_items_to_send.push_back(play_item(FREQ_MAX, MS_W'(1)));
    tone_items_to_send.push_back(play_item(FREQ_W'(1), MS_W'(1)));
    repeat (5) tone_items_to_send.push_back(tick_item());
    repeat (8) tone_items_to_send.push_back(play_item(FREQ_W'($urandom()), MS_W'(3)));
    tone_items_to_send.push_back(play_item(FREQ_MAX, MS_MAX));
    tone_items_to_send.push_back(play_item('0, MS_W'(16'h8000)));
    wait_until_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: clock_setting = CLK_W'(1000);
        1: clock_setting = CLK_W'(16000000);
        2: clock_setting = '1;
        3: clock_setting = '0;
        default: clock_setting = CLK_W'($urandom_range(1000, 16000000));
      endcase
      if (ph == 1) begin
        send_idle_pct = 73;
        recv_idle_pct = 33;
      end else if (ph == 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_timer_clock(clock_setting);
      if (ph == 4) begin
        hold_trigger = 1'b1;
        @(negedge clk);
        hold_trigger = 1'b0;
      end
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_until_drained();
    end

    // drain part of the ring, then queue the longest tone
    repeat (30) tone_items_to_send.push_back(tick_item());
    tone_items_to_send.push_back(play_item(FREQ_MAX, MS_MAX));
    repeat (3) tone_items_to_send.push_back(tick_item());
    wait_until_drained();

    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tqps_pkg.sv
hw/rtl/tqps_stream_if.sv
hw/rtl/tqps_ring.sv
hw/rtl/tqps_div.sv
hw/rtl/tone_queue_pwm_sequencer_unit.sv
tb/sv/tone_queue_pwm_sequencer_unit_test.sv
